>>> rtl/fat12c_pkg.sv
// shared types and constants for the fat12 table clear block
`default_nettype none
package fat12c_pkg;

  localparam logic [11:0] BAD_MARK = 12'hFF7;

  localparam logic [1:0] POS_ZERO = 2'd0;
  localparam logic [1:0] POS_ONE  = 2'd1;
  localparam logic [1:0] POS_TWO  = 2'd2;

  localparam logic [1:0] IDX_FIRST  = 2'd0;
  localparam logic [1:0] IDX_SECOND = 2'd1;

  // one repacked group of one to three words
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       fin;
  } grp_t;

endpackage
`default_nettype wire

>>> rtl/fat12c_front.sv
// front part: gathers table words into groups and clears non-bad entries outside a table's first group
`default_nettype none
module fat12c_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              table_valid,
  output logic                   table_stall,
  input  wire logic [7:0]        table_byte,
  input  wire logic              end_of_table,
  input  wire logic              q_full,
  output logic                   q_push,
  output fat12c_pkg::grp_t       q_rec
);
  import fat12c_pkg::*;

  logic [1:0] pos;
  logic [7:0] g0;
  logic [7:0] g1;
  logic       first;
  logic       accept;
  logic       clr_even;
  logic       clr_odd;
  logic       clr_tail;

  assign table_stall = q_full;
  assign accept      = table_valid && !q_full;

  assign clr_even = !first && ({g1[3:0], g0} != BAD_MARK);
  assign clr_odd  = !first && ({table_byte, g1[7:4]} != BAD_MARK);
  assign clr_tail = !first && ({table_byte[3:0], g0} != BAD_MARK);

  always_comb begin
    q_rec  = '0;
    q_push = 1'b0;
    case (pos)
      POS_TWO: begin
        q_rec.b0  = clr_even ? 8'h00 : g0;
        q_rec.b1  = {(clr_odd ? 4'h0 : g1[7:4]), (clr_even ? 4'h0 : g1[3:0])};
        q_rec.b2  = clr_odd ? 8'h00 : table_byte;
        q_rec.cnt = 2'd3;
        q_rec.fin = end_of_table;
        q_push    = accept;
      end
      POS_ONE: begin
        q_rec.b0  = clr_tail ? 8'h00 : g0;
        q_rec.b1  = {table_byte[7:4], (clr_tail ? 4'h0 : table_byte[3:0])};
        q_rec.cnt = 2'd2;
        q_rec.fin = 1'b1;
        q_push    = accept && end_of_table;
      end
      default: begin
        q_rec.b0  = table_byte;
        q_rec.cnt = 2'd1;
        q_rec.fin = 1'b1;
        q_push    = accept && end_of_table;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= POS_ZERO;
      first <= 1'b1;
    end else if (accept) begin
      if (end_of_table) begin
        pos   <= POS_ZERO;
        first <= 1'b1;
      end else if (pos == POS_TWO) begin
        pos   <= POS_ZERO;
        first <= 1'b0;
      end else if (pos == POS_ONE) begin
        pos <= POS_TWO;
      end else begin
        pos <= POS_ONE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !end_of_table) begin
      if (pos == POS_ONE) begin
        g1 <= table_byte;
      end else if (pos != POS_TWO) begin
        g0 <= table_byte;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fat12c_queue.sv
// two-entry group queue between front and back
`default_nettype none
module fat12c_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire fat12c_pkg::grp_t  push_rec,
  output logic                   full,
  input  wire logic              pop,
  output logic                   not_empty,
  output fat12c_pkg::grp_t       head
);
  import fat12c_pkg::*;

  grp_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/fat12c_back.sv
// back part: sends each queued group out one word per cycle while the receiver does not stall
`default_nettype none
module fat12c_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              q_not_empty,
  input  wire fat12c_pkg::grp_t  q_head,
  output logic                   q_pop,
  output logic                   cleared_valid,
  input  wire logic              cleared_stall,
  output logic [7:0]             cleared_byte,
  output logic                   final_byte
);
  import fat12c_pkg::*;

  grp_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [7:0] sel;
  logic       is_end;
  logic       advance;

  always_comb begin
    case (idx)
      IDX_FIRST:  sel = cur.b0;
      IDX_SECOND: sel = cur.b1;
      default:    sel = cur.b2;
    endcase
  end

  assign is_end  = (idx == (cur.cnt - 2'd1));
  assign advance = cur_valid && (!cleared_valid || !cleared_stall);
  assign q_pop   = q_not_empty && (!cur_valid || (advance && is_end));

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid     <= 1'b0;
      idx           <= IDX_FIRST;
      cleared_valid <= 1'b0;
    end else begin
      if (!cleared_valid || !cleared_stall) begin
        cleared_valid <= cur_valid;
      end
      if (q_pop) begin
        cur_valid <= 1'b1;
        idx       <= IDX_FIRST;
      end else if (advance && is_end) begin
        cur_valid <= 1'b0;
      end else if (advance) begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_head;
    end
    if (advance) begin
      cleared_byte <= sel;
      final_byte   <= is_end && cur.fin;
    end
  end

endmodule
`default_nettype wire

>>> rtl/fat12_clear_keep_bad_clusters_top.sv
// top level of the fat12 table clear that keeps bad-cluster entries
// a group's first word passes the queue, group and output registers; throughput is one word
// per cycle in and out unless stalled, set by the back part's one-word output register
// a two-group queue lets the input keep flowing while the output is stalled
// synchronous reset empties the queue and output and restarts at a table's first group
`default_nettype none
module fat12_clear_keep_bad_clusters_top (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       table_valid,
  output logic            table_stall,
  input  wire logic [7:0] table_byte,
  input  wire logic       end_of_table,
  output logic            cleared_valid,
  input  wire logic       cleared_stall,
  output logic [7:0]      cleared_byte,
  output logic            final_byte
);
  import fat12c_pkg::*;

  grp_t push_rec;
  grp_t head;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  fat12c_front u_front (
    .clk          (clk),
    .rst          (rst),
    .table_valid  (table_valid),
    .table_stall  (table_stall),
    .table_byte   (table_byte),
    .end_of_table (end_of_table),
    .q_full       (full),
    .q_push       (push),
    .q_rec        (push_rec)
  );

  fat12c_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_rec  (push_rec),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  fat12c_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (not_empty),
    .q_head        (head),
    .q_pop         (pop),
    .cleared_valid (cleared_valid),
    .cleared_stall (cleared_stall),
    .cleared_byte  (cleared_byte),
    .final_byte    (final_byte)
  );

endmodule
`default_nettype wire

>>> test/fat12_clear_keep_bad_clusters_top_test.sv
// testbench for the fat12 table clear that keeps bad-cluster entries
module fat12_clear_keep_bad_clusters_top_test;
  import fat12c_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       fin;
  } out_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       table_valid = 1'b0;
  logic       table_stall;
  logic [7:0] table_byte = 8'h00;
  logic       end_of_table = 1'b0;
  logic       cleared_valid;
  logic       cleared_stall = 1'b0;
  logic [7:0] cleared_byte;
  logic       final_byte;

  out_word_t  pending_out[$];
  logic [7:0] table_buf[$];
  logic [7:0] held_byte[2];
  logic [1:0] held_count;
  logic       first_group;
  int         errors = 0;
  int         words_sent = 0;
  int         hold_off_cycles = 0;
  bit         in_gaps_on = 1'b1;
  bit         out_gaps_on = 1'b1;

  fat12_clear_keep_bad_clusters_top dut (
    .clk          (clk),
    .rst          (rst),
    .table_valid  (table_valid),
    .table_stall  (table_stall),
    .table_byte   (table_byte),
    .end_of_table (end_of_table),
    .cleared_valid(cleared_valid),
    .cleared_stall(cleared_stall),
    .cleared_byte (cleared_byte),
    .final_byte   (final_byte)
  );

  always #10 clk = ~clk;

  function automatic void push_word(input logic [7:0] data, input logic fin);
    out_word_t w;
    w.data = data;
    w.fin = fin;
    pending_out.push_back(w);
  endfunction

  // expected words for one accepted table byte
  function automatic void predict_cleared(input logic [7:0] b, input logic eot);
    logic [7:0] c0;
    logic [7:0] c1;
    logic [7:0] c2;
    if (held_count == POS_TWO) begin
      c0 = held_byte[IDX_FIRST[0]];
      c1 = held_byte[IDX_SECOND[0]];
      c2 = b;
      if (!first_group) begin
        if ({c1[3:0], c0} != BAD_MARK) begin
          c0 = 8'h00;
          c1[3:0] = 4'h0;
        end
        if ({c2, c1[7:4]} != BAD_MARK) begin
          c1[7:4] = 4'h0;
          c2 = 8'h00;
        end
      end
      push_word(c0, 1'b0);
      push_word(c1, 1'b0);
      push_word(c2, eot);
      held_count = POS_ZERO;
      first_group = 1'b0;
    end else if (eot) begin
      if (held_count == POS_ZERO) begin
        push_word(b, 1'b1);
      end else begin
        c0 = held_byte[IDX_FIRST[0]];
        c1 = b;
        if (!first_group && {c1[3:0], c0} != BAD_MARK) begin
          c0 = 8'h00;
          c1[3:0] = 4'h0;
        end
        push_word(c0, 1'b0);
        push_word(c1, 1'b1);
      end
    end else begin
      held_byte[held_count[0]] = b;
      held_count = held_count + 2'd1;
    end
    if (eot) begin
      held_count = POS_ZERO;
      first_group = 1'b1;
    end
  endfunction

  task automatic send_word(input logic [7:0] b, input logic eot);
    if (in_gaps_on && $urandom_range(0, 4) == 0) begin
      table_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    table_byte <= b;
    end_of_table <= eot;
    table_valid <= 1'b1;
    do @(posedge clk); while (table_stall);
    predict_cleared(b, eot);
    words_sent++;
  endtask

  task automatic send_table();
    for (int i = 0; i < table_buf.size(); i++) begin
      send_word(table_buf[i], i == table_buf.size() - 1);
    end
  endtask

  task automatic wait_for_drain();
    table_valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  function automatic logic [11:0] pick_entry();
    case ($urandom_range(0, 5))
      0, 1: return BAD_MARK;
      2: return BAD_MARK ^ (12'h001 << $urandom_range(0, 11));
      default: return 12'($urandom_range(0, 4095));
    endcase
  endfunction

  // mostly packed entries with many bad marks, some raw noise
  task automatic build_random_table(input int len);
    logic [11:0] e0;
    logic [11:0] e1;
    bit          raw;
    raw = ($urandom_range(0, 4) == 0);
    table_buf.delete();
    while (table_buf.size() < len) begin
      e0 = pick_entry();
      e1 = pick_entry();
      if (raw) begin
        table_buf.push_back(8'($urandom_range(0, 255)));
        table_buf.push_back(8'($urandom_range(0, 255)));
        table_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        table_buf.push_back(e0[7:0]);
        table_buf.push_back({e1[3:0], e0[11:8]});
        table_buf.push_back(e1[11:4]);
      end
    end
    while (table_buf.size() > len) void'(table_buf.pop_back());
  endtask

  function automatic int random_length();
    if ($urandom_range(0, 7) == 0) return $urandom_range(1, 2);
    return $urandom_range(3, 27);
  endfunction

  task automatic test_directed_cases();
    table_buf = '{8'hF0, 8'hFF, 8'hFF, 8'hF7, 8'h7F, 8'hFF, 8'hF7, 8'hAF, 8'h12,
                  8'h12, 8'h7A, 8'hFF, 8'h00};
    send_table();
    table_buf = '{8'h5A};
    send_table();
    table_buf = '{8'h11, 8'h22};
    send_table();
    table_buf = '{8'hF0, 8'hFF, 8'hFF, 8'hF7, 8'hFF};
    send_table();
    table_buf = '{8'hF0, 8'hFF, 8'hFF, 8'hAB, 8'hCD};
    send_table();
    wait_for_drain();
  endtask

  task automatic test_output_hold_off();
    in_gaps_on = 1'b0;
    hold_off_cycles = 80;
    build_random_table(45);
    send_table();
    wait_for_drain();
    in_gaps_on = 1'b1;
  endtask

  task automatic test_pause_mid_table();
    build_random_table(20);
    for (int i = 0; i < 20; i++) begin
      send_word(table_buf[i], i == 19);
      if (i == 9) wait_for_drain();
    end
    build_random_table(10);
    send_table();
    wait_for_drain();
  endtask

  task automatic test_random_tables(input int count);
    int target;
    target = words_sent + count;
    while (words_sent < target) begin
      build_random_table(random_length());
      send_table();
    end
  endtask

  task automatic test_full_rate(input int count);
    in_gaps_on = 1'b0;
    out_gaps_on = 1'b0;
    test_random_tables(count);
    wait_for_drain();
  endtask

  // receiver stall bursts and the long hold-off
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        cleared_stall <= 1'b1;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (out_gaps_on && $urandom_range(0, 3) == 0) begin
        cleared_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        cleared_stall <= 1'b0;
        repeat (out_gaps_on ? $urandom_range(1, 12) : 1) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && cleared_valid && !cleared_stall) begin
      if (pending_out.size() == 0) begin
        $display("%0t: unexpected word, expected none actual %h fin %b",
                 $time, cleared_byte, final_byte);
        errors++;
      end else begin
        want = pending_out.pop_front();
        if (cleared_byte !== want.data) begin
          $display("%0t: cleared_byte expected %h actual %h", $time, want.data,
                   cleared_byte);
          errors++;
        end
        if (final_byte !== want.fin) begin
          $display("%0t: final_byte expected %b actual %b", $time, want.fin,
                   final_byte);
          errors++;
        end
      end
    end
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    held_byte[IDX_FIRST[0]] = 8'h00;
    held_byte[IDX_SECOND[0]] = 8'h00;
    held_count = POS_ZERO;
    first_group = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_output_hold_off();
    test_pause_mid_table();
    test_random_tables(320);
    test_full_rate(60);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
